// File: sv/pdlc_pkg.sv
// shared types and constants of the password door-lock controller
package pdlc_pkg;

    typedef enum logic [3:0] {
        MODE_BOOT    = 4'd0,
        MODE_FIRST   = 4'd1,
        MODE_IDLE    = 4'd2,
        MODE_OPEN_PW = 4'd3,
        MODE_CHG_OLD = 4'd4,
        MODE_CHG_NEW = 4'd5,
        MODE_OPENING = 4'd6,
        MODE_HOLD    = 4'd7,
        MODE_CLOSING = 4'd8,
        MODE_ALARM   = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        MOTOR_STOP  = 2'd0,
        MOTOR_CW    = 2'd1,
        MOTOR_CCW   = 2'd2
    } motor_t;

    localparam logic [7:0] CMD_OPEN    = 8'h05;
    localparam logic [7:0] CMD_CHANGE  = 8'h08;
    localparam logic [7:0] CMD_ALARM   = 8'hFF;

    localparam logic [7:0] REPLY_ZERO  = 8'h00;
    localparam logic [7:0] REPLY_OK    = 8'h01;
    localparam logic [7:0] REPLY_PHASE = 8'h0C;

    localparam logic [1:0] CFG_MOTOR_RUN = 2'd0;
    localparam logic [1:0] CFG_HOLD      = 2'd1;
    localparam logic [1:0] CFG_ALARM     = 2'd2;
    localparam logic [1:0] CFG_BUZZ_BIT  = 2'd3;

    localparam logic [15:0] MOTOR_RUN_RESET = 16'd1875;
    localparam logic [15:0] HOLD_RESET      = 16'd375;
    localparam logic [15:0] ALARM_RESET     = 16'd7500;
    localparam logic [3:0]  BUZZ_BIT_RESET  = 4'd7;

endpackage

// File: sv/password_door_lock_controller_core.sv
// password door-lock controller: command decode, password store and compare, timed sequences
//
// One transaction (a tick or a received byte) is taken every clock cycle and its result
// appears in the output register on the next cycle; the input stalls only while a finished
// result is held there by output stall. The state update is a single pass of short logic;
// the stored password sits in a small memory whose next byte is read ahead into a register,
// so a compare never waits. The user must write configuration via cfg_we/cfg_index/cfg_data
// only while idle; the block does not check. First transaction after reset: boot reply 0x01.
module password_door_lock_controller_core #(
    parameter int PASSWORD_LENGTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [1:0]  motor_drive,
    output logic        buzzer,
    output logic        busy_res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pdlc_pkg::*;

    localparam int PosW = $clog2(PASSWORD_LENGTH);
    localparam logic [PosW-1:0] LAST_POS = PosW'(PASSWORD_LENGTH - 1);

    logic [15:0]     motor_run_reg;
    logic [15:0]     hold_reg;
    logic [15:0]     alarm_reg;
    logic [3:0]      buzz_bit_reg;

    mode_t           mode_reg, mode_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic            present_reg, present_next;
    logic            failed_reg, failed_next;
    logic            done_reg, done_next;
    logic [15:0]     tick_reg, tick_next;

    logic [7:0]      pw_mem [PASSWORD_LENGTH];
    logic [7:0]      pw_rd_reg;
    logic            mem_we;
    logic [7:0]      mem_wdata;

    logic            out_valid_reg;
    logic            tx_valid_reg;
    logic [7:0]      tx_byte_reg;
    logic [1:0]      motor_reg;
    logic            buzzer_reg;
    logic            busy_reg;

    logic            accept;
    logic            is_byte;
    logic            last;
    logic [7:0]      ch;
    logic            ends;
    logic [16:0]     tick_inc;
    logic [15:0]     limit;
    logic [15:0]     tick_dec;
    logic            txv;
    logic [7:0]      txb;
    logic [1:0]      motor;
    logic            buzz;
    logic            busy;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign is_byte  = opcode;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_run_reg <= MOTOR_RUN_RESET;
            hold_reg      <= HOLD_RESET;
            alarm_reg     <= ALARM_RESET;
            buzz_bit_reg  <= BUZZ_BIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTOR_RUN: motor_run_reg <= cfg_data;
                CFG_HOLD:      hold_reg      <= cfg_data;
                CFG_ALARM:     alarm_reg     <= cfg_data;
                CFG_BUZZ_BIT:  buzz_bit_reg  <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        last      = (pos_reg == LAST_POS);
        ch        = last ? 8'h00 : rx_byte;
        ends      = (ch == 8'h00);
        tick_inc  = {1'b0, tick_reg} + 17'd1;
        limit     = (mode_reg == MODE_HOLD) ? hold_reg : motor_run_reg;

        mode_next    = mode_reg;
        pos_next     = pos_reg;
        present_next = present_reg;
        failed_next  = failed_reg;
        done_next    = done_reg;
        tick_next    = tick_reg;
        mem_we       = 1'b0;
        mem_wdata    = ch;
        txv          = 1'b0;
        txb          = REPLY_ZERO;

        if (accept)
        begin
            case (mode_reg)
                MODE_BOOT:
                begin
                    txv = 1'b1;
                    if (present_reg)
                    begin
                        txb       = REPLY_ZERO;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        txb         = REPLY_OK;
                        mode_next   = MODE_FIRST;
                        pos_next    = '0;
                        failed_next = 1'b0;
                        done_next   = 1'b0;
                    end
                end
                MODE_OPENING, MODE_HOLD, MODE_CLOSING:
                begin
                    if (!is_byte)
                    begin
                        if (tick_inc > {1'b0, limit})
                        begin
                            txv       = 1'b1;
                            txb       = REPLY_PHASE;
                            tick_next = '0;
                            case (mode_reg)
                                MODE_OPENING: mode_next = MODE_HOLD;
                                MODE_HOLD:    mode_next = MODE_CLOSING;
                                default:      mode_next = MODE_IDLE;
                            endcase
                        end
                        else
                        begin
                            tick_next = tick_inc[15:0];
                        end
                    end
                end
                MODE_ALARM:
                begin
                    if (!is_byte)
                    begin
                        tick_next = tick_inc[15:0];
                        if (tick_inc[15:0] == alarm_reg)
                        begin
                            txv       = 1'b1;
                            txb       = REPLY_ZERO;
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_IDLE:
                begin
                    if (is_byte)
                    begin
                        if (rx_byte == CMD_OPEN || rx_byte == CMD_CHANGE)
                        begin
                            mode_next   = (rx_byte == CMD_OPEN) ? MODE_OPEN_PW : MODE_CHG_OLD;
                            pos_next    = '0;
                            failed_next = 1'b0;
                            done_next   = 1'b0;
                        end
                        else if (rx_byte == CMD_ALARM)
                        begin
                            tick_next = '0;
                            mode_next = MODE_ALARM;
                        end
                    end
                end
                MODE_FIRST, MODE_CHG_NEW:
                begin
                    if (is_byte)
                    begin
                        mem_we   = 1'b1;
                        pos_next = ends ? '0 : pos_reg + 1'b1;
                        if (ends)
                        begin
                            if (mode_reg == MODE_FIRST)
                                present_next = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_OPEN_PW, MODE_CHG_OLD:
                begin
                    if (is_byte)
                    begin
                        if (!failed_reg && !done_reg)
                        begin
                            if (pw_rd_reg != ch)
                                failed_next = 1'b1;
                            else if (pw_rd_reg == 8'h00)
                                done_next = 1'b1;
                        end
                        pos_next = ends ? '0 : pos_reg + 1'b1;
                        if (ends)
                        begin
                            txv = 1'b1;
                            txb = failed_next ? REPLY_ZERO : REPLY_OK;
                            if (failed_next)
                                mode_next = MODE_IDLE;
                            else if (mode_reg == MODE_OPEN_PW)
                            begin
                                tick_next = '0;
                                mode_next = MODE_OPENING;
                            end
                            else
                            begin
                                mode_next   = MODE_CHG_NEW;
                                pos_next    = '0;
                                failed_next = 1'b0;
                                done_next   = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        case (mode_next)
            MODE_OPENING: motor = MOTOR_CW;
            MODE_CLOSING: motor = MOTOR_CCW;
            default:      motor = MOTOR_STOP;
        endcase
        tick_dec = tick_next - 16'd1;
        buzz     = (mode_next == MODE_ALARM) && (tick_next != 16'd0) && tick_dec[buzz_bit_reg];
        busy     = mode_next inside {MODE_OPENING, MODE_HOLD, MODE_CLOSING, MODE_ALARM};
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BOOT;
            pos_reg     <= '0;
            present_reg <= 1'b0;
            failed_reg  <= 1'b0;
            done_reg    <= 1'b0;
            tick_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            present_reg <= present_next;
            failed_reg  <= failed_next;
            done_reg    <= done_next;
            tick_reg    <= tick_next;
        end
    end

    // password store, next byte read ahead
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pw_mem[pos_reg] <= mem_wdata;
        pw_rd_reg <= pw_mem[pos_next];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_valid_reg <= txv;
            tx_byte_reg  <= txb;
            motor_reg    <= motor;
            buzzer_reg   <= buzz;
            busy_reg     <= busy;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign motor_drive = motor_reg;
    assign buzzer      = buzzer_reg;
    assign busy_res    = busy_reg;

endmodule
